// ===== hw/rtl/ean8_pkg.sv =====
// shared types, constants and digit tables for the ean-8 scan-line decoder
package ean8_pkg;

	// largest meaningful image dimension, also the clamp for register values
	localparam logic [10:0] MAX_DIM = 11'd1024;
	localparam logic [10:0] RESET_DIM = 11'd256;

	// number of modules across one ean-8 symbol
	localparam int NUM_MODULES = 67;
	localparam logic [6:0] NUM_MODULES_V = 7'd67;

	// (t + 66) / 67 by reciprocal: q = (t * RECIP) >> RECIP_SHIFT, exact for t below 1091
	localparam logic [9:0] RECIP = 10'd979;
	localparam int RECIP_SHIFT = 16;
	localparam logic [13:0] SEG_ROUND = 14'd66;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_GUARD_FAIL,
		STATUS_NO_SCAN_ROW
	} status_t;

	// configuration register indexes
	typedef enum logic {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} reg_index_t;

	// left half (odd parity) and right half digit codes, first module in bit 6
	localparam logic [6:0] LEFT_CODES [10] = '{
		7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
	};
	localparam logic [6:0] RIGHT_CODES [10] = '{
		7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C, 7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
	};

	// table lookup of one 7-module pattern, returns {found, digit}
	function automatic logic [4:0] decode_digit(input logic [6:0] pat, input logic right_half);
		logic [3:0] val;
		logic found;
		logic [6:0] code;
		val = 4'd0;
		found = 1'b0;
		for (int k = 9; k >= 0; k--) begin
			code = right_half ? RIGHT_CODES[k] : LEFT_CODES[k];
			if (code == pat) begin
				val = 4'(k);
				found = 1'b1;
			end
		end
		return {found, val};
	endfunction

endpackage

// ===== hw/rtl/ean8_scanline_decoder_unit.sv =====
// ean-8 scan-line decoder: pixel stream in, decoded digit words out
//
// Takes one bilevel pixel per clock in raster order and never stalls while
// pixels run inside an image: each pixel only updates row/column counters and
// the 67-module sampler. The pixel that ends an image hands the sampled
// modules to a result buffer that sends eight digit words (or one error word)
// on the output, one per cycle while the output is taken. The input stalls
// only when the pixel that ends the next image arrives while words of the
// previous image are still queued and the last of them does not move to the
// output in that cycle. Registers are to be written only between images;
// the user must keep to this, as the block itself does not enforce it.
module ean8_scanline_decoder_unit
	import ean8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// pixel stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] pixel, [7:1] zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [3:0] digit, [6:4] digit_index, [7] digit_found,
	                               // [9:8] status, [15:10] zero
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	// configuration registers
	logic [10:0] width_q, height_q;

	// image tracking state
	logic [9:0]  col_q, row_q;
	logic        rhb_q;
	logic [10:0] tm_q;
	logic        mf_q;
	logic [4:0]  sw_q;
	logic [6:0]  si_q;
	logic [4:0]  sp_q;
	logic [4:0]  bc_q;
	logic [NUM_MODULES-1:0] mb_q;

	// result buffer
	logic                   snap_busy_q;
	logic [NUM_MODULES-1:0] snap_bits_q;
	status_t                snap_status_q;
	logic [2:0]             snap_cnt_q;

	// output register
	logic        out_valid_q;
	logic [3:0]  out_digit_q;
	logic [2:0]  out_idx_q;
	logic        out_found_q;
	status_t     out_status_q;
	logic        out_last_q;

	logic px, acc;
	logic [10:0] w_e, h_e;
	logic [9:0]  h_half;
	logic [10:0] m_cur;
	logic        scan, clr;
	logic [13:0] tv;
	logic [20:0] prod;
	logic [4:0]  sw_calc, sw_e, sp_e, bc_e, bc_inc, sp_inc, bc_n, sp_n;
	logic [6:0]  si_e, si_n;
	logic [NUM_MODULES-1:0] mb_e, mb_n;
	logic        counting, done, flush, bitval;
	logic        row_end, img_end, rhb_n, mf_n;
	logic [10:0] tm_n;
	logic        no_row, guards_ok;
	status_t     fin_status;
	logic        load, snap_free;
	logic [6:0]  pats [8];
	logic [4:0]  dec;

	// clamp register values to the meaningful range
	always_comb begin
		w_e = (width_q == 11'd0) ? 11'd1 : ((width_q > MAX_DIM) ? MAX_DIM : width_q);
		h_e = (height_q == 11'd0) ? 11'd1 : ((height_q > MAX_DIM) ? MAX_DIM : height_q);
	end

	assign px  = s_tdata[0];
	assign acc = s_tvalid & s_tready;
	assign h_half = h_e[10:1];

	// margin and scan row
	assign m_cur = mf_q ? tm_q : {1'b0, row_q};
	assign scan  = ({2'b0, row_q} == ({1'b0, m_cur} + {2'b0, h_half}));
	assign clr   = scan && (col_q == 10'd0);

	// module width (w - 2m + 66) / 67, zero when not positive
	always_comb begin
		tv = {3'b0, w_e} + SEG_ROUND - {2'b0, m_cur, 1'b0};
		prod = tv[10:0] * RECIP;
		sw_calc = (!tv[13] && tv != 14'd0) ? prod[RECIP_SHIFT +: 5] : 5'd0;
	end

	// segment sampler
	always_comb begin
		sw_e = clr ? sw_calc : sw_q;
		si_e = clr ? 7'd0 : si_q;
		sp_e = clr ? 5'd0 : sp_q;
		bc_e = clr ? 5'd0 : bc_q;
		mb_e = clr ? '0 : mb_q;

		row_end = ({1'b0, col_q} + 11'd1) >= w_e;

		counting = scan && (sw_e != 5'd0) && (si_e < NUM_MODULES_V) && ({1'b0, col_q} >= m_cur);
		bc_inc = bc_e + {4'b0, px};
		sp_inc = sp_e + 5'd1;
		bc_n = counting ? bc_inc : bc_e;
		sp_n = counting ? sp_inc : sp_e;
		done = counting && (sp_inc >= sw_e);
		flush = !done && row_end && scan && (si_e < NUM_MODULES_V) && (sp_n != 5'd0);
		bitval = {bc_n, 1'b0} > {1'b0, sw_e};

		mb_n = mb_e;
		if (done || flush) begin
			mb_n[si_e] = bitval;
		end
		si_n = done ? (si_e + 7'd1) : si_e;
		if (done || flush) begin
			sp_n = 5'd0;
			bc_n = 5'd0;
		end
	end

	// margin detection at row end
	always_comb begin
		rhb_n = rhb_q | px;
		mf_n = mf_q;
		tm_n = tm_q;
		if (!mf_q) begin
			if (rhb_n) begin
				mf_n = 1'b1;
				tm_n = {1'b0, row_q};
			end else begin
				tm_n = {1'b0, row_q} + 11'd1;
			end
		end
		img_end = row_end && (({1'b0, row_q} + 11'd1) >= h_e);
	end

	// image status at its last pixel
	always_comb begin
		no_row = !mf_n || (({1'b0, tm_n} + {2'b0, h_half}) >= {1'b0, h_e});
		guards_ok = mb_n[0] & !mb_n[1] & mb_n[2]
			& mb_n[64] & !mb_n[65] & mb_n[66]
			& !mb_n[31] & mb_n[32] & !mb_n[33] & mb_n[34] & !mb_n[35];
		if (no_row) begin
			fin_status = STATUS_NO_SCAN_ROW;
		end else if (!guards_ok) begin
			fin_status = STATUS_GUARD_FAIL;
		end else begin
			fin_status = STATUS_OK;
		end
	end

	// hold off an image-ending pixel while the previous results are queued,
	// unless the last of them moves to the output in this cycle
	assign s_tready = !(snap_busy_q && img_end) || snap_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RESET_DIM;
			height_q <= RESET_DIM;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: width_q <= width_q;
			endcase
		end
	end

	// image state update per accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			rhb_q <= 1'b0;
			tm_q <= '0;
			mf_q <= 1'b0;
			sw_q <= '0;
			si_q <= '0;
			sp_q <= '0;
			bc_q <= '0;
			mb_q <= '0;
		end else if (acc) begin
			if (img_end) begin
				col_q <= '0;
				row_q <= '0;
				rhb_q <= 1'b0;
				tm_q <= '0;
				mf_q <= 1'b0;
				sw_q <= '0;
				si_q <= '0;
				sp_q <= '0;
				bc_q <= '0;
				mb_q <= '0;
			end else begin
				sw_q <= sw_e;
				si_q <= si_n;
				sp_q <= sp_n;
				bc_q <= bc_n;
				mb_q <= mb_n;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 10'd1;
					rhb_q <= 1'b0;
					mf_q <= mf_n;
					tm_q <= tm_n;
				end else begin
					col_q <= col_q + 10'd1;
					rhb_q <= rhb_n;
				end
			end
		end
	end

	// result buffer: one image's modules and status, walked one word per cycle while the output is taken
	assign load = snap_busy_q && (!out_valid_q || m_tready);
	assign snap_free = load && ((snap_status_q != STATUS_OK) || (snap_cnt_q == 3'd7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_busy_q <= 1'b0;
			snap_cnt_q <= '0;
		end else if (acc && img_end) begin
			snap_busy_q <= 1'b1;
			snap_cnt_q <= '0;
		end else if (load) begin
			snap_cnt_q <= snap_cnt_q + 3'd1;
			if (snap_free) begin
				snap_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && img_end) begin
			snap_bits_q <= mb_n;
			snap_status_q <= fin_status;
		end
	end

	// seven-module patterns of the eight digit positions
	always_comb begin
		for (int d = 0; d < 8; d++) begin
			for (int k = 0; k < 7; k++) begin
				pats[d][6-k] = snap_bits_q[((d < 4) ? (3 + 7 * d) : (36 + 7 * (d - 4))) + k];
			end
		end
		dec = decode_digit(pats[snap_cnt_q], snap_cnt_q[2]);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= snap_status_q;
			if (snap_status_q != STATUS_OK) begin
				out_digit_q <= 4'd0;
				out_idx_q <= 3'd0;
				out_found_q <= 1'b0;
				out_last_q <= 1'b1;
			end else begin
				out_digit_q <= dec[3:0];
				out_idx_q <= snap_cnt_q;
				out_found_q <= dec[4];
				out_last_q <= (snap_cnt_q == 3'd7);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_status_q, out_found_q, out_idx_q, out_digit_q};
	assign m_tlast  = out_last_q;

endmodule
